// ===== hdl/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared types, constants and helpers for the escape-time pixel core.
// ----------------------------------------------------------------------------
package mbe_pkg;

	localparam int MAX_ITER   = 1024;
	localparam int ITER_BITS  = $clog2(MAX_ITER);
	localparam int FRAC_BITS  = 28;
	localparam int WORD_W     = 32;
	localparam int PROD_W     = 2 * WORD_W - FRAC_BITS;
	localparam int WIDE_W     = 48;
	localparam int CNT_W      = 11;
	localparam int INTEN_W    = 8;
	localparam int INTEN_MAX  = 255;
	localparam int ROW_W      = 12;
	localparam int COL_W      = 12;
	localparam int STEP_W     = 31;
	localparam int HEIGHT_W   = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	localparam logic signed [WORD_W-1:0] MIN_RE_RST = -32'sd671088640;
	localparam logic signed [WORD_W-1:0] MIN_IM_RST = -32'sd268435456;
	localparam logic [STEP_W-1:0]        STEP_RE_RST = 31'd918401;
	localparam logic [STEP_W-1:0]        STEP_IM_RST = 31'd919300;
	localparam logic [HEIGHT_W-1:0]      HEIGHT_RST  = 13'd585;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_RE       = 3'd0,
		CFG_MIN_IM       = 3'd1,
		CFG_STEP_RE      = 3'd2,
		CFG_STEP_IM      = 3'd3,
		CFG_IMAGE_HEIGHT = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_DONE
	} iter_state_t;

	typedef struct packed {
		logic [ROW_W-1:0] pixel_row;
		logic [COL_W-1:0] pixel_col;
	} pixel_in_t;

	typedef struct packed {
		logic [CNT_W-1:0]   iteration_count;
		logic               escaped;
		logic [INTEN_W-1:0] intensity;
	} pixel_out_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] min_re;
		logic signed [WORD_W-1:0] min_im;
		logic [STEP_W-1:0]        step_re;
		logic [STEP_W-1:0]        step_im;
		logic [HEIGHT_W-1:0]      image_height;
	} cfg_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] c_re;
		logic signed [WORD_W-1:0] c_im;
	} point_t;

	typedef struct packed {
		logic pop;
		logic mul_en;
		logic upd_en;
		logic res_wr;
	} iter_ctrl_t;

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = {{(WIDE_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
		lo = {{(WIDE_W-WORD_W+1){1'b1}}, {(WORD_W-1){1'b0}}};
		if (v > hi) begin
			return hi[WORD_W-1:0];
		end else if (v < lo) begin
			return lo[WORD_W-1:0];
		end
		return v[WORD_W-1:0];
	endfunction

endpackage

// ===== hdl/mbe_front.sv =====
// ----------------------------------------------------------------------------
// mbe_front
// Maps a pixel to its complex point: one multiply stage, one add and clamp stage.
// ----------------------------------------------------------------------------
module mbe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  mbe_pkg::cfg_t      cfg,
	input  logic               pixel_valid,
	output logic               pixel_ready,
	input  mbe_pkg::pixel_in_t pixel,
	output logic               point_valid,
	input  logic               point_ready,
	output mbe_pkg::point_t    point
);

	localparam int RD_W = mbe_pkg::HEIGHT_W + 1;

	logic                               valid_s1;
	logic                               valid_s2;
	logic                               adv_s1;
	logic                               adv_s2;
	logic [mbe_pkg::COL_W+mbe_pkg::STEP_W-1:0] prod_re_s1;
	logic signed [mbe_pkg::WIDE_W-1:0]  prod_im_s1;
	logic signed [RD_W-1:0]             rdist;
	logic signed [mbe_pkg::WIDE_W-1:0]  rdist_ext;
	logic signed [mbe_pkg::WIDE_W-1:0]  step_im_ext;
	logic signed [mbe_pkg::WIDE_W-1:0]  sum_re;
	logic signed [mbe_pkg::WIDE_W-1:0]  sum_im;
	logic signed [mbe_pkg::WIDE_W-1:0]  prod_re_ext;
	logic signed [mbe_pkg::WIDE_W-1:0]  min_re_ext;
	logic signed [mbe_pkg::WIDE_W-1:0]  min_im_ext;
	mbe_pkg::point_t                    point_s2;

	assign adv_s2      = !valid_s2 || point_ready;
	assign adv_s1      = !valid_s1 || adv_s2;
	assign pixel_ready = adv_s1;

	// row distance from the bottom edge, signed
	assign rdist = $signed({1'b0, cfg.image_height}) - RD_W'(1)
		- $signed({{(RD_W-mbe_pkg::ROW_W){1'b0}}, pixel.pixel_row});
	assign rdist_ext   = mbe_pkg::WIDE_W'(rdist);
	assign step_im_ext = $signed({{(mbe_pkg::WIDE_W-mbe_pkg::STEP_W){1'b0}}, cfg.step_im});

	assign prod_re_ext = $signed({{(mbe_pkg::WIDE_W-mbe_pkg::COL_W-mbe_pkg::STEP_W){1'b0}},
		prod_re_s1});
	assign min_re_ext  = mbe_pkg::WIDE_W'(cfg.min_re);
	assign min_im_ext  = mbe_pkg::WIDE_W'(cfg.min_im);
	assign sum_re      = min_re_ext + prod_re_ext;
	assign sum_im      = min_im_ext + prod_im_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pixel_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && pixel_valid) begin
			prod_re_s1 <= pixel.pixel_col * cfg.step_re;
			prod_im_s1 <= rdist_ext * step_im_ext;
		end
		if (adv_s2 && valid_s1) begin
			point_s2.c_re <= mbe_pkg::sat_word(sum_re);
			point_s2.c_im <= mbe_pkg::sat_word(sum_im);
		end
	end

	assign point_valid = valid_s2;
	assign point       = point_s2;

endmodule

// ===== hdl/mbe_fifo.sv =====
// ----------------------------------------------------------------------------
// mbe_fifo
// Short point queue between the mapping front and the iteration engine.
// ----------------------------------------------------------------------------
module mbe_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  mbe_pkg::point_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output mbe_pkg::point_t pop_data
);

	mbe_pkg::point_t                   mem [mbe_pkg::FIFO_DEPTH];
	logic [mbe_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [mbe_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [mbe_pkg::FIFO_PTR_W:0]      fill_q;
	logic                              do_push;
	logic                              do_pop;

	assign push_ready = fill_q != (mbe_pkg::FIFO_PTR_W+1)'(mbe_pkg::FIFO_DEPTH);
	assign pop_valid  = fill_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_data   = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== hdl/mbe_iter.sv =====
// ----------------------------------------------------------------------------
// mbe_iter
// Escape-time engine: z = z*z + c, iterated through a multiply state and an update state, registered result.
// ----------------------------------------------------------------------------
module mbe_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                point_valid,
	output logic                point_ready,
	input  mbe_pkg::point_t     point,
	output logic                result_valid,
	input  logic                result_ready,
	output mbe_pkg::pixel_out_t result
);

	localparam logic signed [mbe_pkg::WIDE_W-1:0] ESC_LIMIT =
		mbe_pkg::WIDE_W'(1) << (mbe_pkg::FRAC_BITS + 2);
	localparam logic [mbe_pkg::CNT_W-1:0] CNT_MAX = mbe_pkg::CNT_W'(mbe_pkg::MAX_ITER);
	localparam int SCL_W = mbe_pkg::CNT_W + mbe_pkg::INTEN_W;

	mbe_pkg::iter_state_t               state_q;
	mbe_pkg::iter_state_t               state_d;
	mbe_pkg::iter_ctrl_t                ctrl;
	mbe_pkg::point_t                    c_q;
	logic signed [mbe_pkg::WORD_W-1:0]  z_re_q;
	logic signed [mbe_pkg::WORD_W-1:0]  z_im_q;
	logic [mbe_pkg::CNT_W-1:0]          cnt_q;
	logic signed [mbe_pkg::PROD_W-1:0]  sr_q;
	logic signed [mbe_pkg::PROD_W-1:0]  si_q;
	logic signed [mbe_pkg::PROD_W-1:0]  cr_q;
	logic signed [2*mbe_pkg::WORD_W-1:0] p_rr;
	logic signed [2*mbe_pkg::WORD_W-1:0] p_ii;
	logic signed [2*mbe_pkg::WORD_W-1:0] p_ri;
	logic signed [mbe_pkg::WIDE_W-1:0]  sr_e;
	logic signed [mbe_pkg::WIDE_W-1:0]  si_e;
	logic signed [mbe_pkg::WIDE_W-1:0]  cr_e;
	logic signed [mbe_pkg::WIDE_W-1:0]  cre_e;
	logic signed [mbe_pkg::WIDE_W-1:0]  cim_e;
	logic signed [mbe_pkg::WIDE_W-1:0]  mag;
	logic signed [mbe_pkg::WIDE_W-1:0]  new_re;
	logic signed [mbe_pkg::WIDE_W-1:0]  new_im;
	logic                               finish;
	logic                               slot_free;
	logic                               esc;
	logic [SCL_W-1:0]                   scaled;
	mbe_pkg::pixel_out_t                res_q;
	logic                               res_valid_q;

	assign p_rr = z_re_q * z_re_q;
	assign p_ii = z_im_q * z_im_q;
	assign p_ri = z_re_q * z_im_q;

	assign sr_e   = mbe_pkg::WIDE_W'(sr_q);
	assign si_e   = mbe_pkg::WIDE_W'(si_q);
	assign cr_e   = mbe_pkg::WIDE_W'(cr_q);
	assign cre_e  = mbe_pkg::WIDE_W'(c_q.c_re);
	assign cim_e  = mbe_pkg::WIDE_W'(c_q.c_im);
	assign mag    = sr_e + si_e;
	assign new_re = sr_e - si_e + cre_e;
	assign new_im = (cr_e <<< 1) + cim_e;

	assign finish    = (cnt_q == CNT_MAX) || (mag >= ESC_LIMIT);
	assign slot_free = !res_valid_q || result_ready;

	assign esc    = cnt_q != CNT_MAX;
	assign scaled = SCL_W'(cnt_q) * SCL_W'(mbe_pkg::INTEN_MAX);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (point_valid) begin
					state_d = mbe_pkg::ST_MUL;
				end
			end
			mbe_pkg::ST_MUL: begin
				state_d = mbe_pkg::ST_UPD;
			end
			mbe_pkg::ST_UPD: begin
				state_d = finish ? mbe_pkg::ST_DONE : mbe_pkg::ST_MUL;
			end
			mbe_pkg::ST_DONE: begin
				if (slot_free) begin
					state_d = mbe_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mbe_pkg::ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			mbe_pkg::ST_IDLE: begin
				ctrl.pop = point_valid;
			end
			mbe_pkg::ST_MUL: begin
				ctrl.mul_en = 1'b1;
			end
			mbe_pkg::ST_UPD: begin
				ctrl.upd_en = !finish;
			end
			mbe_pkg::ST_DONE: begin
				ctrl.res_wr = slot_free;
			end
			default: begin
				ctrl = '0;
			end
		endcase
	end

	assign point_ready = ctrl.pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mbe_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.res_wr) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			c_q    <= point;
			z_re_q <= '0;
			z_im_q <= '0;
			cnt_q  <= '0;
		end
		if (ctrl.mul_en) begin
			sr_q <= mbe_pkg::PROD_W'(p_rr >>> mbe_pkg::FRAC_BITS);
			si_q <= mbe_pkg::PROD_W'(p_ii >>> mbe_pkg::FRAC_BITS);
			cr_q <= mbe_pkg::PROD_W'(p_ri >>> mbe_pkg::FRAC_BITS);
		end
		if (ctrl.upd_en) begin
			z_re_q <= mbe_pkg::sat_word(new_re);
			z_im_q <= mbe_pkg::sat_word(new_im);
			cnt_q  <= cnt_q + 1'b1;
		end
		if (ctrl.res_wr) begin
			res_q.iteration_count <= cnt_q;
			res_q.escaped         <= esc;
			res_q.intensity       <= esc ? scaled[mbe_pkg::ITER_BITS +: mbe_pkg::INTEN_W] : '0;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hdl/mandelbrot_escape_time_pixel_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_pixel_core
// Escape-time pixel core: point mapping front, point queue, iteration engine.
// ----------------------------------------------------------------------------
// the engine works on one point at a time and pops the next only after writing the result,
// while the front and queue keep accepting pixels; the iteration count n is at most 1024
// reset: asynchronous, clears queue, engine and result valid; registers take default plane
module mandelbrot_escape_time_pixel_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mbe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbe_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_ready,
	input  mbe_pkg::pixel_in_t                pixel,
	output logic                              result_valid,
	input  logic                              result_ready,
	output mbe_pkg::pixel_out_t               result
);

	mbe_pkg::cfg_t   cfg_q;
	logic            fr_valid;
	logic            fr_ready;
	mbe_pkg::point_t fr_point;
	logic            q_valid;
	logic            q_ready;
	mbe_pkg::point_t q_point;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_re       <= mbe_pkg::MIN_RE_RST;
			cfg_q.min_im       <= mbe_pkg::MIN_IM_RST;
			cfg_q.step_re      <= mbe_pkg::STEP_RE_RST;
			cfg_q.step_im      <= mbe_pkg::STEP_IM_RST;
			cfg_q.image_height <= mbe_pkg::HEIGHT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				mbe_pkg::CFG_MIN_RE: begin
					cfg_q.min_re <= cfg_data;
				end
				mbe_pkg::CFG_MIN_IM: begin
					cfg_q.min_im <= cfg_data;
				end
				mbe_pkg::CFG_STEP_RE: begin
					cfg_q.step_re <= cfg_data[mbe_pkg::STEP_W-1:0];
				end
				mbe_pkg::CFG_STEP_IM: begin
					cfg_q.step_im <= cfg_data[mbe_pkg::STEP_W-1:0];
				end
				mbe_pkg::CFG_IMAGE_HEIGHT: begin
					cfg_q.image_height <= cfg_data[mbe_pkg::HEIGHT_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	mbe_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.point_valid (fr_valid),
		.point_ready (fr_ready),
		.point       (fr_point)
	);

	mbe_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_point),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_point)
	);

	mbe_iter u_iter (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (q_valid),
		.point_ready  (q_ready),
		.point        (q_point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== bench/tb_mandelbrot_escape_time_pixel_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time_pixel_core
// Self-checking bench for the escape-time pixel core. A scoreboard recomputes
// the escape count of each transferred pixel from its own copy of the plane
// registers and compares every returned result in order. Stimulus covers the
// default plane, register extremes and masking, and random planes with pixels
// biased toward fast escapes, under random idling and result back-pressure.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time_pixel_core;

	localparam int unsigned HOLD_CYCLES  = 2500;
	localparam int unsigned WATCH_LIMIT  = 20000;
	localparam int unsigned TAIL_CYCLES  = 64;
	localparam int unsigned PHASE_PIXELS = 93;
	localparam int unsigned RAND_PHASES  = 6;
	localparam logic [mbe_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE =
		mbe_pkg::CFG_IDX_W'(mbe_pkg::CFG_IMAGE_HEIGHT + 1);

	class escape_checker;
		longint lo_re, lo_im, inc_re, inc_im, rows;
		mbe_pkg::pixel_out_t due_results[$];
		int unsigned n_pixels, n_escaped, n_bounded, n_errors;

		function new();
			lo_re = longint'(mbe_pkg::MIN_RE_RST);
			lo_im = longint'(mbe_pkg::MIN_IM_RST);
			inc_re = longint'(mbe_pkg::STEP_RE_RST);
			inc_im = longint'(mbe_pkg::STEP_IM_RST);
			rows = longint'(mbe_pkg::HEIGHT_RST);
			n_pixels = 0;
			n_escaped = 0;
			n_bounded = 0;
			n_errors = 0;
		endfunction

		function void set_reg(logic [mbe_pkg::CFG_IDX_W-1:0] idx,
			logic [mbe_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				mbe_pkg::CFG_MIN_RE: begin
					lo_re = longint'(signed'(data));
				end
				mbe_pkg::CFG_MIN_IM: begin
					lo_im = longint'(signed'(data));
				end
				mbe_pkg::CFG_STEP_RE: begin
					inc_re = longint'(data[mbe_pkg::STEP_W-1:0]);
				end
				mbe_pkg::CFG_STEP_IM: begin
					inc_im = longint'(data[mbe_pkg::STEP_W-1:0]);
				end
				mbe_pkg::CFG_IMAGE_HEIGHT: begin
					rows = longint'(data[mbe_pkg::HEIGHT_W-1:0]);
				end
				default: begin
				end
			endcase
		endfunction

		function longint clamp_word(longint v);
			if (v > 64'sd2147483647) begin
				return 64'sd2147483647;
			end
			if (v < -64'sd2147483648) begin
				return -64'sd2147483648;
			end
			return v;
		endfunction

		function mbe_pkg::pixel_out_t predict_escape(mbe_pkg::pixel_in_t p);
			mbe_pkg::pixel_out_t r;
			longint row_dist, c_re, c_im, z_re, z_im, sq_re, sq_im, prod_ri, bound;
			int unsigned n;
			bit gone;
			row_dist = rows - 1 - longint'(p.pixel_row);
			c_re = clamp_word(lo_re + longint'(p.pixel_col) * inc_re);
			c_im = clamp_word(lo_im + row_dist * inc_im);
			z_re = 0;
			z_im = 0;
			n = 0;
			gone = 1'b0;
			bound = longint'(1) << (mbe_pkg::FRAC_BITS + 2);
			while (!gone && n < mbe_pkg::MAX_ITER) begin
				sq_re = (z_re * z_re) >>> mbe_pkg::FRAC_BITS;
				sq_im = (z_im * z_im) >>> mbe_pkg::FRAC_BITS;
				if (sq_re + sq_im >= bound) begin
					gone = 1'b1;
				end else begin
					prod_ri = (z_re * z_im) >>> mbe_pkg::FRAC_BITS;
					z_re = clamp_word(sq_re - sq_im + c_re);
					z_im = clamp_word(2 * prod_ri + c_im);
					n++;
				end
			end
			r.iteration_count = mbe_pkg::CNT_W'(n);
			r.escaped = (n < mbe_pkg::MAX_ITER);
			r.intensity = r.escaped ?
				mbe_pkg::INTEN_W'(n * mbe_pkg::INTEN_MAX / mbe_pkg::MAX_ITER) : '0;
			return r;
		endfunction

		function void note_pixel(mbe_pkg::pixel_in_t p);
			mbe_pkg::pixel_out_t r;
			r = predict_escape(p);
			due_results.push_back(r);
			n_pixels++;
			if (r.escaped) begin
				n_escaped++;
			end else begin
				n_bounded++;
			end
		endfunction

		function void check_result(mbe_pkg::pixel_out_t got);
			mbe_pkg::pixel_out_t want;
			if (due_results.size() == 0) begin
				$error("result transfer with no pixel outstanding: iteration_count %0d",
					got.iteration_count);
				n_errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.iteration_count !== want.iteration_count) begin
				$error("iteration_count: expected %0d, actual %0d",
					want.iteration_count, got.iteration_count);
				n_errors++;
			end
			if (got.escaped !== want.escaped) begin
				$error("escaped: expected %0d, actual %0d", want.escaped, got.escaped);
				n_errors++;
			end
			if (got.intensity !== want.intensity) begin
				$error("intensity: expected %0d, actual %0d", want.intensity, got.intensity);
				n_errors++;
			end
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           pixel_valid;
	logic                           pixel_ready;
	mbe_pkg::pixel_in_t             pixel;
	logic                           result_valid;
	logic                           result_ready;
	mbe_pkg::pixel_out_t            result;

	escape_checker board;
	int unsigned   tx_idle;
	int unsigned   rx_idle;
	bit            hold_req;
	int unsigned   n_holds;
	int unsigned   n_writes;
	int unsigned   n_spare;
	int unsigned   n_planes;
	int unsigned   quiet_cycles;

	mandelbrot_escape_time_pixel_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int unsigned pick_gap(input int unsigned idle_pct);
		int unsigned r;
		if ($urandom_range(0, 99) >= idle_pct) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 3);
		end
		if (r < 95) begin
			return $urandom_range(4, 16);
		end
		return $urandom_range(40, 200);
	endfunction

	function automatic mbe_pkg::pixel_in_t pix(input int unsigned row, input int unsigned col);
		mbe_pkg::pixel_in_t p;
		p.pixel_row = mbe_pkg::ROW_W'(row);
		p.pixel_col = mbe_pkg::COL_W'(col);
		return p;
	endfunction

	// favor pixels that escape early, keep some slow and bounded ones
	function automatic mbe_pkg::pixel_in_t pick_pixel();
		mbe_pkg::pixel_in_t p;
		mbe_pkg::pixel_out_t r;
		int unsigned tries;
		p = '0;
		for (tries = 0; tries < 16; tries++) begin
			p = pix($urandom_range(0, 2**mbe_pkg::ROW_W - 1),
				$urandom_range(0, 2**mbe_pkg::COL_W - 1));
			r = board.predict_escape(p);
			if (!r.escaped) begin
				if ($urandom_range(0, 7) == 0) begin
					return p;
				end
			end else if (r.iteration_count < 200 || $urandom_range(0, 1) == 0) begin
				return p;
			end
		end
		return p;
	endfunction

	task automatic send_pixel(input mbe_pkg::pixel_in_t p);
		int unsigned g;
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!pixel_ready);
		board.note_pixel(p);
		@(negedge clk);
		g = pick_gap(tx_idle);
		if (g != 0) begin
			pixel_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
		input logic [mbe_pkg::CFG_DATA_W-1:0] data);
		int unsigned g;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, data);
		n_writes++;
		@(negedge clk);
		g = pick_gap(tx_idle);
		if (g != 0) begin
			cfg_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic set_plane(input logic [mbe_pkg::CFG_DATA_W-1:0] re0,
		input logic [mbe_pkg::CFG_DATA_W-1:0] im0,
		input logic [mbe_pkg::CFG_DATA_W-1:0] dre, input logic [mbe_pkg::CFG_DATA_W-1:0] dim,
		input logic [mbe_pkg::CFG_DATA_W-1:0] height, input bit spare);
		write_reg(mbe_pkg::CFG_MIN_RE, re0);
		write_reg(mbe_pkg::CFG_MIN_IM, im0);
		write_reg(mbe_pkg::CFG_STEP_RE, dre);
		write_reg(mbe_pkg::CFG_STEP_IM, dim);
		write_reg(mbe_pkg::CFG_IMAGE_HEIGHT, height);
		// out of range index must leave the plane untouched
		if (spare) begin
			write_reg(mbe_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_SPARE,
				2**mbe_pkg::CFG_IDX_W - 1)), $urandom());
			n_spare++;
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
		n_planes++;
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			board.check_result(result);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : rx_side
		int unsigned wait_left;
		wait_left = 0;
		n_holds = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && n_holds == 0) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				n_holds++;
				result_ready <= 1'b1;
			end else if (wait_left != 0) begin
				result_ready <= 1'b0;
				wait_left--;
			end else begin
				result_ready <= 1'b1;
				wait_left = pick_gap(rx_idle);
			end
		end
	end

	initial begin : tx_side
		int unsigned ph, k, h;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = mbe_pkg::CFG_MIN_RE;
		cfg_data = '0;
		pixel_valid = 1'b0;
		pixel = '0;
		hold_req = 1'b0;
		n_writes = 0;
		n_spare = 0;
		n_planes = 1;
		tx_idle = 30;
		rx_idle = 30;
		board = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// default plane: corners, rows past the height, points inside the set
		send_pixel(pix(0, 0));
		send_pixel(pix(4095, 4095));
		send_pixel(pix(0, 4095));
		send_pixel(pix(4095, 0));
		send_pixel(pix(292, 731));
		send_pixel(pix(292, 438));
		send_pixel(pix(584, 0));
		send_pixel(pix(292, 0));
		send_pixel(pix(585, 300));
		send_pixel(pix(100, 1023));
		send_pixel(pix(2730, 1365));
		send_pixel(pix(1365, 2730));
		send_pixel(pix(263, 512));
		drain();

		// saturated corners, height zero with upper data bits set
		set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
			32'hFFFF_E000, 1'b1);
		send_pixel(pix(0, 0));
		send_pixel(pix(4095, 4095));
		send_pixel(pix(0, 1));
		send_pixel(pix(4095, 0));
		drain();

		// height one, zero real step
		set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 1'b0);
		send_pixel(pix(0, 0));
		send_pixel(pix(4095, 4095));
		send_pixel(pix(1, 2048));
		send_pixel(pix(0, 4095));
		drain();

		// step top bits and height upper bits masked off, origin stays bounded
		set_plane(32'h0000_0000, 32'h0000_0000, 32'h8000_0001, 32'h8000_0000,
			32'hFFFF_FFFF, 1'b1);
		send_pixel(pix(0, 0));
		send_pixel(pix(4095, 4095));
		drain();

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			tx_idle = (ph == 3) ? 0 : $urandom_range(10, 60);
			rx_idle = (ph == 3) ? 0 : $urandom_range(10, 60);
			h = (ph == 0) ? 2 : $urandom_range(2, 4096);
			if (ph == 4) begin
				set_plane(-32'sd214748365 + $urandom_range(0, 4000000),
					32'sd13421773 + $urandom_range(0, 4000000),
					{1'($urandom_range(0, 1)), 31'($urandom_range(1000, 3000))},
					{1'($urandom_range(0, 1)), 31'($urandom_range(1000, 3000))},
					{19'($urandom()), 13'(h)}, 1'($urandom_range(0, 1)));
			end else begin
				set_plane(-$urandom_range(268435456, 671088640),
					-$urandom_range(107374182, 429496729),
					{1'($urandom_range(0, 1)), 31'($urandom_range(100000, 400000))},
					{1'($urandom_range(0, 1)), 31'($urandom_range(100000, 400000))},
					{19'($urandom()), 13'(h)}, 1'($urandom_range(0, 1)));
			end
			if (ph == 1) begin
				hold_req = 1'b1;
			end
			for (k = 0; k < PHASE_PIXELS; k++) begin
				if (ph == 2 && k == PHASE_PIXELS / 2) begin
					drain();
				end
				send_pixel(pick_pixel());
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("summary: %0d pixels over %0d plane settings, %0d register writes %s",
			board.n_pixels, n_planes, n_writes, "including unused indexes");
		$display("summary: %0d writes to unused indexes, %0d escaped, %0d bounded, %0d hold-offs",
			n_spare, board.n_escaped, board.n_bounded, n_holds);
		if (board.n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
